// ===== sv/assert_macros.svh =====
// Assertion macros shared by the strike timer RTL.
// No dependencies; the macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every edge outside reset.
`define SSPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");
// Condition must never be seen outside reset.
`define SSPT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define SSPT_ASSERT(lbl, clk, rst_n, prop)
`define SSPT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== sv/sspt_pkg.sv =====
// Package of the solenoid strike pulse timer: widths, constants, queue and divider types.
// No dependencies.
package sspt_pkg;

  localparam int KnobW    = 10;
  localparam int OnTimeW  = 12;
  localparam int DriveW   = 8;
  localparam int RateW    = 12;
  localparam int ElapsedW = 12;
  localparam int PeriodW  = 16;
  localparam int ProdW    = 22;
  localparam int DivDW    = ProdW;
  localparam int DivVW    = 12;

  localparam int KnobMax    = 1023;
  localparam int PowerDen   = KnobMax - 1;
  localparam int DriveMax   = 128;
  localparam int MsPerMin   = 60000;
  localparam int ElapsedMax = 4095;

  // reciprocals of the two map denominators, ceil(2^RecipSh / den); exact for any
  // knob product below 2^ProdW
  localparam int RecipSh = 32;
  localparam int RecipW  = 23;
  localparam logic [RecipW-1:0] PowerRecip =
    RecipW'(((64'd1 << RecipSh) + 64'(PowerDen) - 64'd1) / 64'(PowerDen));
  localparam logic [RecipW-1:0] RateRecip =
    RecipW'(((64'd1 << RecipSh) + 64'(KnobMax) - 64'd1) / 64'(KnobMax));

  localparam int QDepth = 2;

  localparam int DefMinRate  = 20;
  localparam int DefMaxRate  = 2600;
  localparam int DefMinDrive = 60;

  // classified beat, as held in the queue
  typedef struct packed {
    logic               rate_knob_zero;
    logic               power_knob_zero;
    logic [ProdW-1:0]   power_prod;
    logic [ProdW-1:0]   rate_prod;
    logic [OnTimeW-1:0] on_time;
  } sspt_entry_t;

  typedef struct packed {
    logic             coil_on;
    logic [DriveW-1:0] duty;
    logic [RateW-1:0]  strikes_per_min;
    logic [DriveW-1:0] power_level;
  } sspt_out_t;

  typedef struct packed {
    logic             start;
    logic [DivDW-1:0] dividend;
    logic [DivVW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/sspt_if.sv =====
// Valid/ready channel interfaces for the strike timer input and result beats.
// Depends on sspt_pkg.
interface sspt_in_if import sspt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KnobW-1:0]   rate_knob;
  logic [KnobW-1:0]   power_knob;
  logic [OnTimeW-1:0] on_time_ms;

  modport source(output valid, rate_knob, power_knob, on_time_ms, input ready);
  modport sink(input valid, rate_knob, power_knob, on_time_ms, output ready);
endinterface

interface sspt_out_if import sspt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              coil_on;
  logic [DriveW-1:0] duty;
  logic [RateW-1:0]  strikes_per_min;
  logic [DriveW-1:0] power_level;

  modport source(output valid, coil_on, duty, strikes_per_min, power_level, input ready);
  modport sink(input valid, coil_on, duty, strikes_per_min, power_level, output ready);
endinterface

// ===== sv/solenoid_strike_pulse_timer.sv =====
// Top level of the solenoid strike pulse timer: front end, queue, back end, divider.
// Depends on sspt_pkg, sspt_if, sspt_front, sspt_div and sspt_back.
//
// Each input beat is one millisecond tick with the rate knob, the power knob and the
// coil on-time. The front end accepts a beat, flags zero knobs and forms the knob
// products; a two-deep queue then decouples it from the back end. The back end maps
// power to MinDrive..128 (knob 0 gives 0), maps rate to MinRate..MaxRate strikes per
// minute, derives the strike period as 60000 / rate ms, steps the strike timer and
// registers one result beat per tick: coil state, duty (mapped power while the coil is
// on), the mapped rate (0 when the rate knob is 0) and the mapped power. Both knob maps
// divide by a constant and are done in the map state by reciprocal multiplication; the
// period goes through a restoring divider that retires one quotient bit per cycle. A
// tick steps through fetch, map, divide and commit, the commit waiting for a free result
// slot; the divider sets the sustained rate. Up to two more ticks queue in front while
// a tick is worked or its result waits to be taken. The elapsed count saturates at 4095
// ms, so a period beyond that never expires. The user must write drive_enabled (reset 1)
// via cfg_we_i / cfg_wdata_i only while the block is idle; the block does not enforce it.
// When 0 a strike leaves the coil off, while a coil already on still times out normally.
module solenoid_strike_pulse_timer import sspt_pkg::*; #(
  parameter int MinRate  = DefMinRate,
  parameter int MaxRate  = DefMaxRate,
  parameter int MinDrive = DefMinDrive
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  sspt_in_if.sink    in_i,
  sspt_out_if.source out_o
);

  logic        entry_valid;
  logic        pop;
  sspt_entry_t entry;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // classify and queue incoming beats
  sspt_front #(
    .MinRate (MinRate),
    .MaxRate (MaxRate),
    .MinDrive(MinDrive)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .pop_i        (pop),
    .entry_valid_o(entry_valid),
    .entry_o      (entry)
  );

  // divider for the strike period
  sspt_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // timer state, drive enable and the result register
  sspt_back #(
    .MinRate (MinRate),
    .MaxRate (MaxRate),
    .MinDrive(MinDrive)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .entry_valid_i(entry_valid),
    .entry_i      (entry),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_o        (out_o)
  );

endmodule

// ===== sv/sspt_front.sv =====
// Front end: takes input beats, forms the knob products and flags, queues them.
// Depends on sspt_pkg, sspt_if and assert_macros.svh.
`include "assert_macros.svh"

module sspt_front import sspt_pkg::*; #(
  parameter int MinRate  = DefMinRate,
  parameter int MaxRate  = DefMaxRate,
  parameter int MinDrive = DefMinDrive
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sspt_in_if.sink     in_i,
  input  logic        pop_i,
  output logic        entry_valid_o,
  output sspt_entry_t entry_o
);

  localparam int RateDiff  = MaxRate - MinRate;
  localparam int RateMag   = (RateDiff < 0) ? -RateDiff : RateDiff;
  localparam int PowerSpan = DriveMax - MinDrive;
  localparam int QIdxW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);

  sspt_entry_t      mem_q [QDepth];
  logic [QIdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push;
  sspt_entry_t      new_entry;
  logic [KnobW-1:0] knob_m1;

  assign in_i.ready = (cnt_q < QCntW'(QDepth));
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    knob_m1                   = in_i.power_knob - KnobW'(1);
    new_entry.rate_knob_zero  = (in_i.rate_knob == '0);
    new_entry.power_knob_zero = (in_i.power_knob == '0);
    new_entry.power_prod      = new_entry.power_knob_zero ? '0
                              : ProdW'(knob_m1) * ProdW'(PowerSpan);
    new_entry.rate_prod       = ProdW'(in_i.rate_knob) * ProdW'(RateMag);
    new_entry.on_time         = in_i.on_time_ms;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QIdxW'(QDepth - 1)) ? '0 : wr_q + QIdxW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QIdxW'(QDepth - 1)) ? '0 : rd_q + QIdxW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_entry;
    end
  end

  assign entry_valid_o = (cnt_q != '0);
  assign entry_o       = mem_q[rd_q];

  `SSPT_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCntW'(QDepth))
  `SSPT_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> (cnt_q != '0))

endmodule

// ===== sv/sspt_div.sv =====
// Restoring divider for the strike period, one quotient bit per cycle.
// Depends on sspt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sspt_div import sspt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DivDW + 1);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivVW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DivDW-1:0] quo_q, quo_d;
  logic [DivVW:0]   trial, diff;
  logic             fits;

  always_comb begin
    trial  = {rem_q, quo_q[DivDW-1]};
    fits   = (trial >= {1'b0, dvs_q});
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivDW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = fits ? diff[DivVW-1:0] : trial[DivVW-1:0];
        quo_d = {quo_q[DivDW-2:0], fits};
        cnt_d = cnt_q - CntW'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quot = quo_q;

  // partial remainder always below the divisor
  `SSPT_ASSERT(a_rem_below, clk_i, rst_ni, busy_q |-> (rem_q < dvs_q))

endmodule

// ===== sv/sspt_back.sv =====
// Back end: maps knobs by reciprocal multiplication, divides for the period, runs the timer.
// Depends on sspt_pkg, sspt_if and assert_macros.svh.
`include "assert_macros.svh"

module sspt_back import sspt_pkg::*; #(
  parameter int MinRate  = DefMinRate,
  parameter int MaxRate  = DefMaxRate,
  parameter int MinDrive = DefMinDrive
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        entry_valid_i,
  input  sspt_entry_t entry_i,
  output logic        pop_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  sspt_out_if.source  out_o
);

  localparam bit RateNeg = (MaxRate < MinRate);
  localparam int MulW    = ProdW + RecipW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAP  = 4'b0010,
    S_DIVT = 4'b0100,
    S_DONE = 4'b1000
  } back_state_e;

  back_state_e         state_q, state_d;
  sspt_entry_t         cur_q, cur_d;
  logic [DriveW-1:0]   power_q, power_d, pow_calc;
  logic [RateW-1:0]    rate_q, rate_d;
  logic [RateW:0]      rate_sum;
  logic [MulW-1:0]     pow_mul, rate_mul;
  logic [PeriodW-1:0]  period_q, period_d;
  logic [ElapsedW-1:0] el_q, el_d, el_inc;
  logic                run_q, run_d, coil_q, coil_d, drive_en_q;
  logic                out_valid_q, out_valid_d, slot_free;
  sspt_out_t           out_q, out_d;

  // quotients by the constant denominators: product times reciprocal, upper bits
  assign pow_mul   = MulW'(cur_q.power_prod) * MulW'(PowerRecip);
  assign rate_mul  = MulW'(cur_q.rate_prod) * MulW'(RateRecip);

  assign slot_free = !out_valid_q || out_o.ready;
  assign pow_calc  = pow_mul[RecipSh +: DriveW] + DriveW'(MinDrive);
  assign rate_sum  = RateNeg ? ((RateW+1)'(MinRate) - (RateW+1)'(rate_mul[RecipSh +: RateW]))
                             : ((RateW+1)'(MinRate) + (RateW+1)'(rate_mul[RecipSh +: RateW]));
  assign el_inc    = (run_q && el_q != ElapsedW'(ElapsedMax)) ? el_q + ElapsedW'(1) : el_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    power_d     = power_q;
    rate_d      = rate_q;
    period_d    = period_q;
    el_d        = el_q;
    run_d       = run_q;
    coil_d      = coil_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    pop_o       = 1'b0;
    div_req_o   = '{start: 1'b0, dividend: '0, divisor: '0};
    unique case (state_q)
      S_IDLE: begin
        if (entry_valid_i) begin
          pop_o   = 1'b1;
          cur_d   = entry_i;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        power_d            = cur_q.power_knob_zero ? '0 : pow_calc;
        rate_d             = rate_sum[RateW-1:0];
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivDW'(MsPerMin);
        div_req_o.divisor  = rate_sum[DivVW-1:0];
        state_d            = S_DIVT;
      end
      S_DIVT: begin
        if (div_rsp_i.done) begin
          period_d = div_rsp_i.quot[PeriodW-1:0];
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          el_d = el_inc;
          priority if (cur_q.rate_knob_zero || power_q == '0) begin
            coil_d = 1'b0;
            run_d  = 1'b0;
            el_d   = '0;
          end else if (run_q && PeriodW'(el_inc) >= period_q) begin
            el_d   = '0;
            coil_d = drive_en_q;
          end else if (!run_q) begin
            run_d = 1'b1;
            el_d  = '0;
          end else if (coil_q && el_inc > cur_q.on_time) begin
            coil_d = 1'b0;
          end else begin
            coil_d = coil_q;
          end
          out_valid_d           = 1'b1;
          out_d.coil_on         = coil_d;
          out_d.duty            = coil_d ? power_q : '0;
          out_d.strikes_per_min = cur_q.rate_knob_zero ? '0 : rate_q;
          out_d.power_level     = power_q;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      el_q        <= '0;
      run_q       <= 1'b0;
      coil_q      <= 1'b0;
      drive_en_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      el_q        <= el_d;
      run_q       <= run_d;
      coil_q      <= coil_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        drive_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    power_q  <= power_d;
    rate_q   <= rate_d;
    period_q <= period_d;
    out_q    <= out_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.coil_on         = out_q.coil_on;
  assign out_o.duty            = out_q.duty;
  assign out_o.strikes_per_min = out_q.strikes_per_min;
  assign out_o.power_level     = out_q.power_level;

  `SSPT_ASSERT(a_done_in_div, clk_i, rst_ni, div_rsp_i.done |-> (state_q == S_DIVT))
  `SSPT_ASSERT(a_commit_shows, clk_i, rst_ni,
    (state_q == S_DONE && slot_free) |=> (out_valid_q && state_q == S_IDLE))
  `SSPT_ASSERT(a_duty_match, clk_i, rst_ni,
    (out_valid_q && out_q.coil_on) |-> (out_q.duty == out_q.power_level))

endmodule
